// File: rtl/spr_pkg.sv
// ----------------------------------------------------------------------------
// spr_pkg
// Shared constants, weight tables and types of the spectral-to-RGB pixel block.
// ----------------------------------------------------------------------------
package spr_pkg;

  localparam int BANDS_PER_PIXEL = 36;
  localparam int SAMPLE_BITS     = 16;
  localparam int SAMPLE_W        = 16;                  // port width
  localparam int TABLE_BANDS     = 36;                  // bands with CIE weights
  localparam int BAND_W          = $clog2(BANDS_PER_PIXEL);
  localparam int TIDX_W          = $clog2(TABLE_BANDS);
  localparam int WEIGHT_W        = 16;                  // Q0.16
  localparam int PROD_W          = SAMPLE_W + WEIGHT_W;
  localparam int ACC_W           = 40;
  localparam int HALF_W          = ACC_W / 2;
  localparam int MAT_W           = 19;                  // signed Q3.16
  localparam int MPROD_W         = MAT_W + HALF_W + 1;
  localparam int P_W             = 64;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

  // sum of the Y column, millionths
  localparam longint unsigned YSUM = 64'd10685305;

  function automatic logic [WEIGHT_W-1:0] wq(input longint unsigned raw);
    return WEIGHT_W'((raw * 64'd65536 + YSUM / 2) / YSUM);
  endfunction

  localparam logic [WEIGHT_W-1:0] W_X [TABLE_BANDS] = '{
    wq(1368), wq(4243), wq(14310), wq(43510), wq(134380), wq(283900),
    wq(348280), wq(336200), wq(290800), wq(195360), wq(95640), wq(32010),
    wq(4900), wq(9300), wq(63270), wq(165500), wq(290400), wq(433450),
    wq(594500), wq(762100), wq(916300), wq(1026300), wq(1062200), wq(1002600),
    wq(854450), wq(642400), wq(447900), wq(283500), wq(164900), wq(87400),
    wq(46770), wq(22700), wq(11359), wq(5790), wq(2899), wq(1440)};

  localparam logic [WEIGHT_W-1:0] W_Y [TABLE_BANDS] = '{
    wq(39), wq(120), wq(396), wq(1210), wq(4000), wq(11600),
    wq(23000), wq(38000), wq(60000), wq(90980), wq(139020), wq(208020),
    wq(323000), wq(503000), wq(710000), wq(862000), wq(954000), wq(994950),
    wq(995000), wq(952000), wq(870000), wq(757000), wq(631000), wq(503000),
    wq(381000), wq(265000), wq(175000), wq(107000), wq(61000), wq(32000),
    wq(17000), wq(8210), wq(4102), wq(2091), wq(1047), wq(520)};

  localparam logic [WEIGHT_W-1:0] W_Z [TABLE_BANDS] = '{
    wq(6450), wq(20050), wq(67850), wq(207400), wq(645600), wq(1385600),
    wq(1747060), wq(1772110), wq(1669200), wq(1287640), wq(812950), wq(465180),
    wq(272000), wq(158200), wq(78250), wq(42160), wq(20300), wq(8750),
    wq(3900), wq(2100), wq(1650), wq(1100), wq(800), wq(340),
    wq(190), wq(50), wq(20), wq(0), wq(0), wq(0),
    wq(0), wq(0), wq(0), wq(0), wq(0), wq(0)};

  // XYZ-to-RGB, rounded half away from zero, rows R, G, B
  localparam logic signed [MAT_W-1:0] MAT [3][3] = '{
    '{19'sd201873, -19'sd100755, -19'sd35582},
    '{-19'sd60370, 19'sd122941,  19'sd2965},
    '{19'sd3466,   -19'sd13370,  19'sd75440}};

  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
    logic [ACC_W-1:0] z;
  } xyz_t;

endpackage

// File: rtl/spr_front.sv
// ----------------------------------------------------------------------------
// spr_front
// Band counter and XYZ multiply-accumulate; pushes finished pixel sums.
// ----------------------------------------------------------------------------
module spr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [spr_pkg::SAMPLE_W-1:0]  sample,
  input  logic                          sample_valid,
  output logic                          sample_ready,
  output logic                          push_valid,
  input  logic                          push_ready,
  output spr_pkg::xyz_t                 push_data
);

  logic [spr_pkg::BAND_W-1:0]   band;
  logic                         s1_valid;
  logic                         s1_last;
  logic [spr_pkg::PROD_W-1:0]   px, py, pz;
  logic [spr_pkg::ACC_W-1:0]    acc_x, acc_y, acc_z;
  logic [spr_pkg::ACC_W-1:0]    sum_x, sum_y, sum_z;
  logic [spr_pkg::SAMPLE_W-1:0] s;
  logic [spr_pkg::WEIGHT_W-1:0] wx, wy, wz;
  logic                         last_band;
  logic                         in_table;
  logic                         advance;
  logic                         accept;

  assign s         = sample & spr_pkg::SAMPLE_MASK;
  assign last_band = band == spr_pkg::BAND_W'(spr_pkg::BANDS_PER_PIXEL - 1);
  assign in_table  = int'(band) < spr_pkg::TABLE_BANDS;

  // bands past the table carry zero weight
  assign wx = in_table ? spr_pkg::W_X[spr_pkg::TIDX_W'(band)] : '0;
  assign wy = in_table ? spr_pkg::W_Y[spr_pkg::TIDX_W'(band)] : '0;
  assign wz = in_table ? spr_pkg::W_Z[spr_pkg::TIDX_W'(band)] : '0;

  // product stage holds while a finished pixel waits for queue space
  assign advance      = !(s1_valid && s1_last && !push_ready);
  assign sample_ready = advance;
  assign accept       = sample_valid && advance;

  assign sum_x = acc_x + spr_pkg::ACC_W'(px);
  assign sum_y = acc_y + spr_pkg::ACC_W'(py);
  assign sum_z = acc_z + spr_pkg::ACC_W'(pz);

  assign push_valid  = s1_valid && s1_last;
  assign push_data.x = sum_x;
  assign push_data.y = sum_y;
  assign push_data.z = sum_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      band     <= '0;
      s1_valid <= 1'b0;
      s1_last  <= 1'b0;
      acc_x    <= '0;
      acc_y    <= '0;
      acc_z    <= '0;
    end else if (advance) begin
      s1_valid <= accept;
      if (accept) begin
        px      <= s * wx;
        py      <= s * wy;
        pz      <= s * wz;
        s1_last <= last_band;
        band    <= last_band ? '0 : band + 1'b1;
      end
      if (s1_valid) begin
        if (s1_last) begin
          acc_x <= '0;
          acc_y <= '0;
          acc_z <= '0;
        end else begin
          acc_x <= sum_x;
          acc_y <= sum_y;
          acc_z <= sum_z;
        end
      end
    end
  end

endmodule

// File: rtl/spr_queue.sv
// ----------------------------------------------------------------------------
// spr_queue
// Two-entry queue of pixel XYZ sums between front and back.
// ----------------------------------------------------------------------------
module spr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  spr_pkg::xyz_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output spr_pkg::xyz_t pop_data
);

  spr_pkg::xyz_t mem [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/spr_back.sv
// ----------------------------------------------------------------------------
// spr_back
// Matrix stage: 18 pipelined 19x21 products into three channel bytes.
// ----------------------------------------------------------------------------
module spr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  spr_pkg::xyz_t pop_data,
  output logic [7:0]    red,
  output logic [7:0]    green,
  output logic [7:0]    blue,
  output logic          rgb_valid,
  input  logic          rgb_ready
);

  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;

  state_t                           state;
  spr_pkg::xyz_t                    acc;
  logic [1:0]                       row;
  logic [2:0]                       sub;      // 0..5: column = sub/2, half = sub[0]
  logic                             mul_on;
  logic signed [spr_pkg::MPROD_W-1:0] prod;
  logic                             prod_v;
  logic                             prod_hi;
  logic                             prod_last;
  logic [1:0]                       prod_row;
  logic                             fin_v;
  logic [1:0]                       fin_row;
  logic signed [spr_pkg::P_W-1:0]   p_acc;
  logic [7:0]                       ch [3];

  logic [1:0]                       col;
  logic [spr_pkg::ACC_W-1:0]        acc_sel;
  logic [spr_pkg::HALF_W-1:0]       half;
  logic signed [spr_pkg::P_W-1:0]   prod_ext;
  logic signed [spr_pkg::P_W-1:0]   term;
  logic signed [spr_pkg::P_W-1:0]   p_base;

  // floor((p*255 + 2^44) / 2^45) in 64-bit wrap, clamped; p <= 0 gives 0
  function automatic logic [7:0] to_byte(input logic signed [spr_pkg::P_W-1:0] p);
    logic [spr_pkg::P_W-1:0] t;
    logic [18:0]             q;
    t = (spr_pkg::P_W'(p) << 8) - spr_pkg::P_W'(p) + (64'd1 << 44);
    q = t[63:45];
    if (p[spr_pkg::P_W-1] || p == '0) return 8'd0;
    if (q > 19'd255) return 8'd255;
    return q[7:0];
  endfunction

  assign col = sub[2:1];
  always_comb begin
    case (col)
      2'd0:    acc_sel = acc.x;
      2'd1:    acc_sel = acc.y;
      default: acc_sel = acc.z;
    endcase
  end
  assign half = sub[0] ? acc_sel[spr_pkg::ACC_W-1:spr_pkg::HALF_W]
                       : acc_sel[spr_pkg::HALF_W-1:0];

  assign prod_ext = {{(spr_pkg::P_W - spr_pkg::MPROD_W){prod[spr_pkg::MPROD_W-1]}}, prod};
  assign term     = prod_hi ? (prod_ext <<< spr_pkg::HALF_W) : prod_ext;
  assign p_base   = fin_v ? '0 : p_acc;

  assign pop_ready = state == IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      mul_on    <= 1'b0;
      prod_v    <= 1'b0;
      fin_v     <= 1'b0;
      rgb_valid <= 1'b0;
      p_acc     <= '0;
      row       <= '0;
      sub       <= '0;
    end else begin
      // multiply step
      prod_v <= 1'b0;
      if (state == RUN && mul_on) begin
        prod      <= spr_pkg::MAT[row][col] * $signed({1'b0, half});
        prod_v    <= 1'b1;
        prod_hi   <= sub[0];
        prod_last <= sub == 3'd5;
        prod_row  <= row;
        if (sub == 3'd5) begin
          sub <= '0;
          row <= row + 2'd1;
          if (row == 2'd2) mul_on <= 1'b0;
        end else begin
          sub <= sub + 3'd1;
        end
      end

      // accumulate step; a row's sum restarts while the last one is rounded
      if (prod_v || fin_v) p_acc <= p_base + (prod_v ? term : '0);
      fin_v   <= prod_v && prod_last;
      fin_row <= prod_row;
      if (fin_v) ch[fin_row] <= to_byte(p_acc);

      if (rgb_valid && rgb_ready) rgb_valid <= 1'b0;

      unique case (state)
        IDLE: begin
          if (pop_valid) begin
            acc    <= pop_data;
            row    <= '0;
            sub    <= '0;
            mul_on <= 1'b1;
            state  <= RUN;
          end
        end
        RUN: begin
          if (fin_v && fin_row == 2'd2) state <= DONE;
        end
        DONE: begin
          if (!rgb_valid || rgb_ready) begin
            red       <= ch[0];
            green     <= ch[1];
            blue      <= ch[2];
            rgb_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// File: rtl/spectral_to_rgb_pixel.sv
// ----------------------------------------------------------------------------
// spectral_to_rgb_pixel
// Band samples of one pixel in, one CIE 1931 based RGB byte triple out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (sample, sample_valid/sample_ready) takes one band sample
//   per item, bands 380 nm to 730 nm in order, 36 items per pixel.
//   Output channel (red/green/blue, rgb_valid/rgb_ready) gives one item per
//   pixel, after its last band.
// Throughput: one sample item per cycle while no pixel waits for queue space.
//   The back end takes one pixel at a time; its single 19x21 multiplier steps
//   18 partial products (3 rows x 3 columns x 2 halves of each 40-bit sum).
// Path: last-band product registers, queue entry, back-end operand, product,
//   row-sum and channel registers, then the output register with rgb_valid.
// Stall: a waiting result sits in the output register; the back end keeps
//   working into its channel registers, and a two-entry queue holds further
//   pixel sums. Only with all of that full does sample_ready drop, and then
//   only at a pixel's last band.
// Reset: rst (synchronous) clears the band counter, the sums, the queue and
//   the output valid; the next sample is band 0 of a new pixel.
// ----------------------------------------------------------------------------
module spectral_to_rgb_pixel (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [spr_pkg::SAMPLE_W-1:0] sample,
  input  logic                         sample_valid,
  output logic                         sample_ready,
  output logic [7:0]                   red,
  output logic [7:0]                   green,
  output logic [7:0]                   blue,
  output logic                         rgb_valid,
  input  logic                         rgb_ready
);

  // front -> queue
  logic          push_valid;
  logic          push_ready;
  spr_pkg::xyz_t push_data;

  // queue -> back
  logic          pop_valid;
  logic          pop_ready;
  spr_pkg::xyz_t pop_data;

  // band counter and XYZ multiply-accumulate, one sample per cycle while no finished pixel waits for queue space
  spr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  // decouples the per-sample front from the per-pixel matrix stage
  spr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // XYZ-to-RGB matrix, rounding, clamp and output register
  spr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .rgb_valid (rgb_valid),
    .rgb_ready (rgb_ready)
  );

endmodule

// File: rtl/spr_checker.sv
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks of the spectral-to-RGB pixel block, bound to the top.
// ----------------------------------------------------------------------------
module spr_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         sample_valid,
  input  logic                         sample_ready,
  input  logic [7:0]                   red,
  input  logic [7:0]                   green,
  input  logic [7:0]                   blue,
  input  logic                         rgb_valid,
  input  logic                         rgb_ready
);

  logic [spr_pkg::BAND_W-1:0] band;
  logic [3:0]                 pending;   // pixels completed but not delivered
  logic                       pix_in;
  logic                       pix_out;

  assign pix_in  = sample_valid && sample_ready &&
                   band == spr_pkg::BAND_W'(spr_pkg::BANDS_PER_PIXEL - 1);
  assign pix_out = rgb_valid && rgb_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      band    <= '0;
      pending <= '0;
    end else begin
      if (sample_valid && sample_ready) begin
        band <= (band == spr_pkg::BAND_W'(spr_pkg::BANDS_PER_PIXEL - 1)) ? '0
                                                                          : band + 1'b1;
      end
      pending <= pending + {3'd0, pix_in} - {3'd0, pix_out};
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !rgb_valid)
    else $error("rgb_valid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    rgb_valid && !rgb_ready |=> rgb_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled rgb item changed");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    rgb_valid |-> pending != 4'd0)
    else $error("rgb item without a completed pixel");

  a_bounded_backlog: assert property (@(posedge clk) disable iff (rst)
    pending <= 4'd5)
    else $error("more pixels in flight than the block can hold");

  a_ready_on_space: assert property (@(posedge clk) disable iff (rst)
    pending == 4'd0 |-> sample_ready)
    else $error("input stalled with no pixel in flight");

endmodule

bind spectral_to_rgb_pixel spr_checker u_spr_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_ready (sample_ready),
  .red          (red),
  .green        (green),
  .blue         (blue),
  .rgb_valid    (rgb_valid),
  .rgb_ready    (rgb_ready)
);

// File: tb/spectral_to_rgb_pixel_test.sv
// ----------------------------------------------------------------------------
// spectral_to_rgb_pixel_test
// Streams pixels of 36 band samples into the spectral-to-RGB block and checks
// every RGB item against a typed answer or a bit-exact model of the CIE
// weighting, XYZ-to-RGB matrix, rounding and clamp. Known pixels from a short
// table go first, then random spectra under several idle and stall mixes.
// ----------------------------------------------------------------------------
module spectral_to_rgb_pixel_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXEL_BANDS = spr_pkg::BANDS_PER_PIXEL;
  localparam int CMF_BANDS   = 36;               // bands with CIE weights
  localparam int SW          = spr_pkg::SAMPLE_W;
  localparam logic [SW-1:0] SMASK = SW'((33'd1 << spr_pkg::SAMPLE_BITS) - 1);

  localparam int RAND_PIXELS   = 6;              // per idling phase
  localparam int HOLD_CYCLES   = 400;            // long receiver hold-off
  localparam int TAIL_CYCLES   = 40;             // idle tail before the verdict
  localparam int WATCHDOG_MAX  = 4000;           // cycles with no item moved

  // CIE 1931 tables in millionths, 380..730 nm
  localparam int unsigned CMF_X [CMF_BANDS] = '{
    1368, 4243, 14310, 43510, 134380, 283900, 348280, 336200, 290800,
    195360, 95640, 32010, 4900, 9300, 63270, 165500, 290400, 433450,
    594500, 762100, 916300, 1026300, 1062200, 1002600, 854450, 642400,
    447900, 283500, 164900, 87400, 46770, 22700, 11359, 5790, 2899, 1440};
  localparam int unsigned CMF_Y [CMF_BANDS] = '{
    39, 120, 396, 1210, 4000, 11600, 23000, 38000, 60000, 90980, 139020,
    208020, 323000, 503000, 710000, 862000, 954000, 994950, 995000, 952000,
    870000, 757000, 631000, 503000, 381000, 265000, 175000, 107000, 61000,
    32000, 17000, 8210, 4102, 2091, 1047, 520};
  localparam int unsigned CMF_Z [CMF_BANDS] = '{
    6450, 20050, 67850, 207400, 645600, 1385600, 1747060, 1772110, 1669200,
    1287640, 812950, 465180, 272000, 158200, 78250, 42160, 20300, 8750,
    3900, 2100, 1650, 1100, 800, 340, 190, 50, 20, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  // XYZ-to-RGB ratios, row by row
  localparam longint XFORM_NUM [9] = '{
    1219569, -608687, -107481,
    -80960619, 82435961, 3976797,
    93813, -180961, 107481};
  localparam longint XFORM_DEN [9] = '{
    395920, 395920, 197960,
    87888100, 43944050, 87888100,
    1774030, 887015, 93370};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // spectrum shapes for a pixel
  typedef enum logic [2:0] {
    SHAPE_FLAT,      // same level in every band
    SHAPE_ONE_BAND,  // level in one band, zero elsewhere
    SHAPE_ALT,       // level and its complement, alternating
    SHAPE_NOISE,     // full-range random per band
    SHAPE_SCALED,    // random per band, shifted down
    SHAPE_SPARSE,    // a few random bands lit
    SHAPE_RAMP       // rising toward the red end
  } shape_e;

  typedef struct packed {
    shape_e      shape;
    logic [15:0] level;
    logic [5:0]  band;
    logic        fixed;   // expected RGB typed in below
    rgb_t        rgb;
  } pixel_row_t;

  // Directed pixels. Fixed rows carry the answer; the rest go to the model.
  localparam int N_ROWS = 12;
  localparam pixel_row_t PIXEL_ROWS [N_ROWS] = '{
    '{SHAPE_FLAT,     16'h0000, 6'd0,  1'b1, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_FLAT,     16'hFFFF, 6'd0,  1'b1, '{8'd255, 8'd255, 8'd255}},
    '{SHAPE_FLAT,     16'h0001, 6'd0,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_FLAT,     16'h2000, 6'd0,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_FLAT,     16'h8000, 6'd0,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_ONE_BAND, 16'hFFFF, 6'd0,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_ONE_BAND, 16'hFFFF, 6'd7,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_ONE_BAND, 16'hFFFF, 6'd20, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_ONE_BAND, 16'hFFFF, 6'd23, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_ONE_BAND, 16'hFFFF, 6'd35, 1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_ALT,      16'hAAAA, 6'd0,  1'b0, '{8'd0,   8'd0,   8'd0}},
    '{SHAPE_ALT,      16'h5555, 6'd0,  1'b0, '{8'd0,   8'd0,   8'd0}}};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic [SW-1:0] sample = '0;
  logic          sample_valid = 1'b0;
  logic          sample_ready;
  logic [7:0]    red;
  logic [7:0]    green;
  logic [7:0]    blue;
  logic          rgb_valid;
  logic          rgb_ready = 1'b0;

  // model state
  logic [15:0] wt_x [CMF_BANDS];
  logic [15:0] wt_y [CMF_BANDS];
  logic [15:0] wt_z [CMF_BANDS];
  longint      xform [9];
  int          band_idx;
  logic [39:0] sum_x, sum_y, sum_z;

  rgb_t       pending_rgb [$];   // RGB items still owed by the block
  pixel_row_t fixed_rgb_q [$];   // per directed pixel: typed answer or not

  int send_idle  = 0;            // percent of cycles the sender idles
  int recv_stall = 0;            // percent of cycles the receiver stalls
  int hold_req   = 0;            // bumped to ask for a long hold-off
  int hold_done  = 0;
  int hold_left  = 0;
  int idle_cycles = 0;
  int mismatches = 0;

  spectral_to_rgb_pixel u_top (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .rgb_valid    (rgb_valid),
    .rgb_ready    (rgb_ready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the block
  // --------------------------------------------------------------------------

  // one output byte from the three XYZ sums; P is in 2^-45 units
  function automatic logic [7:0] rgb_byte_of(input int row, input logic [39:0] ax,
                                              input logic [39:0] ay,
                                              input logic [39:0] az);
    longint          px;
    longint unsigned scaled;
    longint unsigned q;
    px = xform[row*3] * longint'({24'd0, ax}) + xform[row*3+1] * longint'({24'd0, ay})
       + xform[row*3+2] * longint'({24'd0, az});
    if (px <= 0)
      return 8'd0;          // negative channel: black
    scaled = longint'(px) * 64'd255 + (64'd1 << 44);
    q = scaled >> 45;
    return (q > 64'd255) ? 8'd255 : q[7:0];   // overbright saturates
  endfunction

  // accumulate one accepted band; queue a result at the last band
  task automatic absorb_band(input logic [SW-1:0] raw);
    logic [15:0] s;
    rgb_t        px;
    s = raw & SMASK;
    if (band_idx < CMF_BANDS) begin
      // products wrap in the 40-bit sums
      sum_x = sum_x + s * wt_x[band_idx];
      sum_y = sum_y + s * wt_y[band_idx];
      sum_z = sum_z + s * wt_z[band_idx];
    end
    if (band_idx + 1 < PIXEL_BANDS) begin
      band_idx = band_idx + 1;
    end else begin
      px.red   = rgb_byte_of(0, sum_x, sum_y, sum_z);
      px.green = rgb_byte_of(1, sum_x, sum_y, sum_z);
      px.blue  = rgb_byte_of(2, sum_x, sum_y, sum_z);
      // a directed pixel with a typed answer overrides the model
      if (fixed_rgb_q.size() != 0) begin
        if (fixed_rgb_q[0].fixed)
          px = fixed_rgb_q[0].rgb;
        void'(fixed_rgb_q.pop_front());
      end
      pending_rgb = {pending_rgb, px};
      band_idx = 0;
      sum_x = '0;
      sum_y = '0;
      sum_z = '0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: predict on every accepted sample, check every accepted RGB item
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready)
        absorb_band(sample);
      if (rgb_valid && rgb_ready) begin
        if (pending_rgb.size() == 0) begin
          $display("%0t: unexpected item red=%0d green=%0d blue=%0d",
                   $realtime, red, green, blue);
          mismatches++;
        end else begin
          if (red !== pending_rgb[0].red) begin
            $display("%0t: red expected %0d actual %0d", $realtime,
                     pending_rgb[0].red, red);
            mismatches++;
          end
          if (green !== pending_rgb[0].green) begin
            $display("%0t: green expected %0d actual %0d", $realtime,
                     pending_rgb[0].green, green);
            mismatches++;
          end
          if (blue !== pending_rgb[0].blue) begin
            $display("%0t: blue expected %0d actual %0d", $realtime,
                     pending_rgb[0].blue, blue);
            mismatches++;
          end
          void'(pending_rgb.pop_front());
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      rgb_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_done != hold_req) begin
      rgb_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= hold_done + 1;
    end else begin
      rgb_ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // Watchdog: nothing moving for too long means the block is stuck
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (rgb_valid && rgb_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("%0t: no item moved for %0d cycles", $realtime, idle_cycles);
      $display("FAIL spectral_to_rgb_pixel");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------

  // offer one band sample, with random idle cycles ahead of it
  task automatic send_sample(input logic [SW-1:0] value);
    while ($urandom_range(0, 99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample       <= value;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready)
      @(posedge clk);
  endtask

  // one pixel: PIXEL_BANDS samples shaped by the spectrum style
  task automatic send_pixel(input shape_e shape, input logic [15:0] level,
                            input int hot);
    logic [SW-1:0] s;
    for (int b = 0; b < PIXEL_BANDS; b++) begin
      case (shape)
        SHAPE_FLAT:     s = level;
        SHAPE_ONE_BAND: s = (b == hot) ? level : '0;
        SHAPE_ALT:      s = b[0] ? ~level : level;
        SHAPE_NOISE:    s = SW'($urandom);
        SHAPE_SCALED:   s = SW'($urandom) >> hot;
        SHAPE_SPARSE:   s = ($urandom_range(0, 5) == 0) ? SW'($urandom_range(0, level)) : '0;
        default:        s = SW'((32'(level) * b) / PIXEL_BANDS);
      endcase
      send_sample(s);
    end
  endtask

  // stop offering and wait until every owed RGB item has arrived
  task automatic wait_drained();
    sample_valid <= 1'b0;
    do
      @(posedge clk);
    while (pending_rgb.size() != 0);
  endtask

  initial begin
    longint unsigned ysum;
    pixel_row_t      row;
    shape_e          shape;
    logic [15:0]     level;
    int              hot;

    // Q0.16 weights with 1/Ysum folded in, rounded to nearest
    ysum = 0;
    for (int b = 0; b < CMF_BANDS; b++)
      ysum += CMF_Y[b];
    for (int b = 0; b < CMF_BANDS; b++) begin
      wt_x[b] = 16'((64'(CMF_X[b]) * 64'd65536 + ysum / 2) / ysum);
      wt_y[b] = 16'((64'(CMF_Y[b]) * 64'd65536 + ysum / 2) / ysum);
      wt_z[b] = 16'((64'(CMF_Z[b]) * 64'd65536 + ysum / 2) / ysum);
    end
    // Q3.16 matrix, rounded half away from zero
    for (int k = 0; k < 9; k++) begin
      if (XFORM_NUM[k] < 0)
        xform[k] = -(((-XFORM_NUM[k]) * 65536 + XFORM_DEN[k] / 2) / XFORM_DEN[k]);
      else
        xform[k] = (XFORM_NUM[k] * 65536 + XFORM_DEN[k] / 2) / XFORM_DEN[k];
    end
    band_idx = 0;
    sum_x = '0;
    sum_y = '0;
    sum_z = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed pixels, light idling on both sides
    send_idle  = 10;
    recv_stall = 10;
    for (int r = 0; r < N_ROWS; r++) begin
      row = PIXEL_ROWS[r];
      fixed_rgb_q = {fixed_rgb_q, row};
      send_pixel(row.shape, row.level, int'(row.band));
    end
    wait_drained();

    // random spectra: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 64; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 64; end
        default: begin send_idle = 18; recv_stall = 18; end
      endcase
      // first phase: receiver holds off while the sender keeps pushing, so
      // the output register, back end and queue fill and sample_ready drops
      if (phase == 0)
        hold_req <= hold_req + 1;
      for (int p = 0; p < RAND_PIXELS; p++) begin
        hot = 0;
        case ($urandom_range(0, 5))
          0: begin shape = SHAPE_FLAT;     level = 16'($urandom_range(0, 12000)); end
          1: begin
            shape = SHAPE_ONE_BAND;
            level = 16'($urandom);
            hot   = $urandom_range(0, PIXEL_BANDS - 1);
          end
          2: begin shape = SHAPE_NOISE;    level = '0; end
          3: begin
            shape = SHAPE_SCALED;
            level = '0;
            hot   = $urandom_range(0, 8);
          end
          4: begin shape = SHAPE_SPARSE;   level = 16'($urandom); end
          default: begin shape = SHAPE_RAMP; level = 16'($urandom_range(0, 20000)); end
        endcase
        send_pixel(shape, level, hot);
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("PASS spectral_to_rgb_pixel");
    else
      $display("FAIL spectral_to_rgb_pixel");
    $finish;
  end

endmodule

// File: filelist.f
rtl/spr_pkg.sv
rtl/spr_front.sv
rtl/spr_queue.sv
rtl/spr_back.sv
rtl/spectral_to_rgb_pixel.sv
rtl/spr_checker.sv
tb/spectral_to_rgb_pixel_test.sv
